// ===== rtl/tss_pkg.sv =====
// Shared constants and types for the triangular system solver.
// No dependencies; used by tss_div and triangular_system_solver_top.

package tss_pkg;

	localparam int DATA_W        = 32;
	localparam int MAX_DIM_DEF   = 16;
	localparam int FRAC_BITS_DEF = 16;

	// row, column and result counters: 5 bits, wide enough for 0..16
	localparam int CNT_W = 5;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int SIZE_W     = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE      = 1'd1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

	localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [1:0] {
		REQ_MATRIX = 2'd0,
		REQ_RHS    = 2'd1,
		REQ_SOLVE  = 2'd2
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROW_RD,
		ST_ROW_INIT,
		ST_MAC_RD,
		ST_MAC_MUL,
		ST_MAC_ACC,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_ROW_WR,
		ST_OUT_RD,
		ST_OUT_PUT,
		ST_OUT_HOLD
	} state_t;

endpackage

// ===== rtl/tss_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module tss_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/tss_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tss_pkg for the divisor width.

module tss_div #(
	parameter int DVD_W = 48,
	parameter int DVS_W = tss_pkg::DATA_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0] quo,
	output logic             done
);

	localparam int CW = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// dividend bits shift out the top while quotient bits shift in
			if (fits) begin
				rem_q <= DVS_W'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[DVS_W-1:0];
			end
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// ===== rtl/triangular_system_solver_top.sv =====
// Triangular system solver: loads matrix / rhs entries and solves A y = b
// by forward or backward substitution in signed fixed point.
// Depends on tss_pkg, tss_ram and tss_div.
//
// channel | direction | handshake           | payload
// --------+-----------+---------------------+---------------------------------------------
// in      | in        | in_valid / in_stall  | req_type, row_index, col_index, entry_value
// out     | out       | out_valid / out_stall| solution_index, solution_value,
//         |           |                      | singular_pivot, last_result
// cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// Loads are accepted while the solver is idle and may follow back to back.
// A solve holds in_stall high until its last result is taken: each row runs its
// off-diagonal terms, then the bit-serial divider (skipped for a zero pivot), and
// finally the results are presented one by one while out_stall stays low.
// out_stall holds the result register and the sequencer; nothing is lost.
// Reset clears control state and returns configuration to its defaults; stores are not cleared.

module triangular_system_solver_top #(
	parameter int MAX_DIM   = tss_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = tss_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,

	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            req_type,
	input  logic [3:0]                            row_index,
	input  logic [3:0]                            col_index,
	input  logic signed [tss_pkg::DATA_W-1:0]     entry_value,

	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [3:0]                            solution_index,
	output logic signed [tss_pkg::DATA_W-1:0]     solution_value,
	output logic                                  singular_pivot,
	output logic                                  last_result,

	input  logic                                  cfg_we,
	input  logic [tss_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [tss_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int DW        = tss_pkg::DATA_W;
	localparam int CW        = tss_pkg::CNT_W;
	localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
	localparam int MAT_AW    = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
	localparam int SOLVE_CAP = (MAX_DIM < 16) ? MAX_DIM : 16;
	localparam int CAP_W     = (SOLVE_CAP > 1) ? $clog2(SOLVE_CAP) : 1;
	localparam int DVD_W     = DW + FRAC_BITS;
	localparam int PROD_W    = 2 * DW;

	function automatic logic [MAT_AW-1:0] mat_addr(input logic [CW-1:0] r,
			input logic [CW-1:0] c);
		return MAT_AW'(32'(r) * MAX_DIM + 32'(c));
	endfunction

	tss_pkg::state_t state_q, state_d;

	// configuration
	logic                        dir_q;
	logic [tss_pkg::SIZE_W-1:0]  size_q;
	logic [CW-1:0]               n_eff;

	// sequencer counters
	logic [CW-1:0] n_q, i_q, j_q, k_q;
	logic [CW-1:0] lo, hi, j_inc;

	// datapath
	logic signed [DW-1:0]     acc_q;
	logic signed [DW-1:0]     diag_q;
	logic signed [DW-1:0]     y_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] prod_sh;
	logic signed [PROD_W:0]   diff;
	logic [DW-1:0]            acc_next;
	logic [SOLVE_CAP-1:0]     sing_q;
	logic [DW-1:0]            acc_abs, diag_abs;
	logic                     quo_neg;
	logic [DVD_W-1:0]         quo_mag;
	logic                     quo_done;
	logic [DW-1:0]            y_div;

	// store ports
	logic                 in_xfer, out_xfer;
	logic                 mat_we, rhs_we, sol_we;
	logic [MAT_AW-1:0]    mat_waddr, mat_raddr;
	logic [IDX_W-1:0]     rhs_raddr, sol_raddr;
	logic [DW-1:0]        mat_rdata, rhs_rdata, sol_rdata;
	logic                 div_start;

	// output register
	logic                 out_valid_q;
	logic [3:0]           sol_idx_q;
	logic [DW-1:0]        sol_val_q;
	logic                 sing_out_q;
	logic                 last_q;

	assign in_stall = (state_q != tss_pkg::ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= 1'b0;
			size_q <= tss_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tss_pkg::CFG_DIRECTION: dir_q  <= cfg_data[0];
				tss_pkg::CFG_SIZE:      size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (size_q == '0) begin
			n_eff = CW'(1);
		end else if (32'(size_q) > SOLVE_CAP) begin
			n_eff = CW'(SOLVE_CAP);
		end else begin
			n_eff = CW'(size_q);
		end
	end

	// ---------------- loads ----------------
	always_comb begin
		mat_we = 1'b0;
		rhs_we = 1'b0;
		if (in_xfer) begin
			unique case (tss_pkg::req_t'(req_type))
				tss_pkg::REQ_MATRIX:
					mat_we = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
				tss_pkg::REQ_RHS:
					rhs_we = (32'(row_index) < MAX_DIM);
				default: ;
			endcase
		end
	end

	assign mat_waddr = mat_addr(CW'(row_index), CW'(col_index));

	// ---------------- sequencer ----------------
	assign lo    = dir_q ? (i_q + 1'b1) : '0;
	assign hi    = dir_q ? n_q : i_q;
	assign j_inc = j_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mat_raddr = mat_addr(i_q, j_q);
		rhs_raddr = IDX_W'(i_q);
		sol_raddr = IDX_W'(j_q);
		sol_we    = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			tss_pkg::ST_IDLE: begin
				if (in_xfer && tss_pkg::req_t'(req_type) == tss_pkg::REQ_SOLVE) begin
					state_d = tss_pkg::ST_ROW_RD;
				end
			end
			tss_pkg::ST_ROW_RD: begin
				mat_raddr = mat_addr(i_q, i_q);
				state_d   = tss_pkg::ST_ROW_INIT;
			end
			tss_pkg::ST_ROW_INIT: begin
				state_d = (lo < hi) ? tss_pkg::ST_MAC_RD : tss_pkg::ST_DIV_START;
			end
			tss_pkg::ST_MAC_RD:  state_d = tss_pkg::ST_MAC_MUL;
			tss_pkg::ST_MAC_MUL: state_d = tss_pkg::ST_MAC_ACC;
			tss_pkg::ST_MAC_ACC: begin
				state_d = (j_inc < hi) ? tss_pkg::ST_MAC_RD : tss_pkg::ST_DIV_START;
			end
			tss_pkg::ST_DIV_START: begin
				if (diag_q == '0) begin
					state_d = tss_pkg::ST_ROW_WR;
				end else begin
					div_start = 1'b1;
					state_d   = tss_pkg::ST_DIV_WAIT;
				end
			end
			tss_pkg::ST_DIV_WAIT: begin
				if (quo_done) begin
					state_d = tss_pkg::ST_ROW_WR;
				end
			end
			tss_pkg::ST_ROW_WR: begin
				sol_we = 1'b1;
				if (dir_q ? (i_q == '0) : (i_q == n_q - 1'b1)) begin
					state_d = tss_pkg::ST_OUT_RD;
				end else begin
					state_d = tss_pkg::ST_ROW_RD;
				end
			end
			tss_pkg::ST_OUT_RD: begin
				sol_raddr = IDX_W'(k_q);
				state_d   = tss_pkg::ST_OUT_PUT;
			end
			tss_pkg::ST_OUT_PUT: state_d = tss_pkg::ST_OUT_HOLD;
			tss_pkg::ST_OUT_HOLD: begin
				if (out_xfer) begin
					state_d = last_q ? tss_pkg::ST_IDLE : tss_pkg::ST_OUT_RD;
				end
			end
			default: state_d = tss_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			i_q    <= '0;
			j_q    <= '0;
			k_q    <= '0;
			sing_q <= '0;
		end else begin
			unique case (state_q)
				tss_pkg::ST_IDLE: begin
					if (in_xfer) begin
						n_q <= n_eff;
						i_q <= dir_q ? (n_eff - 1'b1) : '0;
					end
				end
				tss_pkg::ST_ROW_INIT: j_q <= lo;
				tss_pkg::ST_MAC_ACC:  j_q <= j_inc;
				tss_pkg::ST_DIV_START: sing_q[i_q[CAP_W-1:0]] <= (diag_q == '0);
				tss_pkg::ST_ROW_WR: begin
					i_q <= dir_q ? (i_q - 1'b1) : (i_q + 1'b1);
					k_q <= '0;
				end
				tss_pkg::ST_OUT_HOLD: begin
					if (out_xfer) begin
						k_q <= k_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- arithmetic ----------------
	// floor of the product scaled down, then saturating subtract
	assign prod_sh = prod_q >>> FRAC_BITS;
	assign diff    = {{(PROD_W-DW+1){acc_q[DW-1]}}, acc_q} - {prod_sh[PROD_W-1], prod_sh};

	always_comb begin
		if (diff[PROD_W:DW-1] == '0 || diff[PROD_W:DW-1] == '1) begin
			acc_next = diff[DW-1:0];
		end else begin
			acc_next = diff[PROD_W] ? tss_pkg::SAT_MIN : tss_pkg::SAT_MAX;
		end
	end

	assign acc_abs  = acc_q[DW-1]  ? (~acc_q + 1'b1)  : acc_q;
	assign diag_abs = diag_q[DW-1] ? (~diag_q + 1'b1) : diag_q;
	assign quo_neg  = acc_q[DW-1] ^ diag_q[DW-1];

	tss_div #(
		.DVD_W (DVD_W),
		.DVS_W (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({acc_abs, {FRAC_BITS{1'b0}}}),
		.divisor  (diag_abs),
		.quo      (quo_mag),
		.done     (quo_done)
	);

	// truncated quotient, sign applied, saturated
	always_comb begin
		if (!quo_neg) begin
			y_div = (quo_mag[DVD_W-1:DW-1] != '0) ? tss_pkg::SAT_MAX : quo_mag[DW-1:0];
		end else if (quo_mag[DVD_W-1:DW] != '0
				|| (quo_mag[DW-1] && quo_mag[DW-2:0] != '0)) begin
			y_div = tss_pkg::SAT_MIN;
		end else begin
			y_div = ~quo_mag[DW-1:0] + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tss_pkg::ST_ROW_INIT: begin
				acc_q  <= rhs_rdata;
				diag_q <= mat_rdata;
			end
			tss_pkg::ST_MAC_MUL: prod_q <= $signed(mat_rdata) * $signed(sol_rdata);
			tss_pkg::ST_MAC_ACC: acc_q  <= acc_next;
			tss_pkg::ST_DIV_START: y_q  <= '0;
			tss_pkg::ST_DIV_WAIT: begin
				if (quo_done) begin
					y_q <= y_div;
				end
			end
			default: ;
		endcase
	end

	// ---------------- stores ----------------
	tss_ram #(
		.WIDTH (DW),
		.DEPTH (MAT_DEPTH)
	) u_mat_ram (
		.clk   (clk),
		.we    (mat_we),
		.waddr (mat_waddr),
		.wdata (entry_value),
		.raddr (mat_raddr),
		.rdata (mat_rdata)
	);

	tss_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_DIM)
	) u_rhs_ram (
		.clk   (clk),
		.we    (rhs_we),
		.waddr (IDX_W'(row_index)),
		.wdata (entry_value),
		.raddr (rhs_raddr),
		.rdata (rhs_rdata)
	);

	tss_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_DIM)
	) u_sol_ram (
		.clk   (clk),
		.we    (sol_we),
		.waddr (IDX_W'(i_q)),
		.wdata (y_q),
		.raddr (sol_raddr),
		.rdata (sol_rdata)
	);

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == tss_pkg::ST_OUT_PUT) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tss_pkg::ST_OUT_PUT) begin
			sol_idx_q  <= k_q[3:0];
			sol_val_q  <= sol_rdata;
			sing_out_q <= sing_q[k_q[CAP_W-1:0]];
			last_q     <= (k_q == n_q - 1'b1);
		end
	end

	assign out_valid      = out_valid_q;
	assign solution_index = sol_idx_q;
	assign solution_value = sol_val_q;
	assign singular_pivot = sing_out_q;
	assign last_result    = last_q;

endmodule
